@@ rtl/tts_pkg.sv @@
// Package for the terminal text screen engine.
// Holds the geometry, the command codes, the FSM states and the walk descriptor.
// No dependencies.
package tts_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 24;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned ADDR_W  = ROW_W + COL_W;
  localparam int unsigned DEPTH   = ROWS << COL_W;

  localparam logic [7:0]       BLANK    = 8'hA0;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  typedef enum logic [4:0] {
    REQ_PUT      = 5'd0,
    REQ_GOTO     = 5'd1,
    REQ_CR       = 5'd2,
    REQ_LF       = 5'd3,
    REQ_RI       = 5'd4,
    REQ_BS       = 5'd5,
    REQ_REGION   = 5'd6,
    REQ_IL       = 5'd7,
    REQ_DL       = 5'd8,
    REQ_ICH      = 5'd9,
    REQ_DCH      = 5'd10,
    REQ_ECH      = 5'd11,
    REQ_EL_END   = 5'd12,
    REQ_EL_START = 5'd13,
    REQ_EL_ALL   = 5'd14,
    REQ_ED_START = 5'd15,
    REQ_ED_END   = 5'd16,
    REQ_ED_ALL   = 5'd17,
    REQ_ATTR     = 5'd18,
    REQ_SAVE     = 5'd19,
    REQ_RESTORE  = 5'd20,
    REQ_READ     = 5'd21
  } req_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_READ,
    ST_DONE
  } state_e;

  // One pass over a cell range; each destination cell takes its source cell
  // (shifted along one axis by delta), or blank when fill_blank is set or the source leaves [lo, hi].
  typedef struct packed {
    logic [ROW_W-1:0] r0;
    logic [COL_W-1:0] c0;
    logic [ROW_W-1:0] r1;
    logic [COL_W-1:0] c1;
    logic             down;
    logic             on_row;
    logic signed [9:0] delta;
    logic [7:0]       lo;
    logic [7:0]       hi;
    logic             fill_blank;
    logic             src_alt;
    logic             dst_alt;
  } walk_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic              blank;
    logic              src_alt;
    logic              dst_alt;
  } wr_t;

endpackage

@@ rtl/tts_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Read of an address written in the same cycle returns the old data.
// No dependencies.
module tts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tts_walker.sv @@
// Cell walker: steps through a range one cell per cycle, reads the source
// cell and writes the destination in the cycle after. Depends on tts_pkg.
module tts_walker import tts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  walk_t             desc_i,
  output logic [ADDR_W-1:0] raddr_o,
  output wr_t               wr_o,
  output logic              idle_o
);

  logic             busy_q, busy_d;
  logic [ROW_W-1:0] pos_r_q, pos_r_d;
  logic [COL_W-1:0] pos_c_q, pos_c_d;
  walk_t            desc_q;
  wr_t              wr_q, wr_d;

  logic signed [9:0] ax, src;
  logic              src_ok;

  always_comb begin
    ax     = desc_q.on_row ? 10'(pos_r_q) : 10'(pos_c_q);
    src    = ax + desc_q.delta;
    src_ok = (src >= $signed({2'b00, desc_q.lo})) && (src <= $signed({2'b00, desc_q.hi}));
    raddr_o = desc_q.on_row ? {src[ROW_W-1:0], pos_c_q} : {pos_r_q, src[COL_W-1:0]};
  end

  always_comb begin
    busy_d  = busy_q;
    pos_r_d = pos_r_q;
    pos_c_d = pos_c_q;
    wr_d    = '0;
    if (start_i) begin
      busy_d  = 1'b1;
      pos_r_d = desc_i.r0;
      pos_c_d = desc_i.c0;
    end else if (busy_q) begin
      wr_d.we      = 1'b1;
      wr_d.addr    = {pos_r_q, pos_c_q};
      wr_d.blank   = desc_q.fill_blank | ~src_ok;
      wr_d.src_alt = desc_q.src_alt;
      wr_d.dst_alt = desc_q.dst_alt;
      if (pos_r_q == desc_q.r1 && pos_c_q == desc_q.c1) begin
        busy_d = 1'b0;
      end else if (desc_q.down) begin
        if (pos_c_q == '0) begin
          pos_c_d = LAST_COL;
          pos_r_d = pos_r_q - 1'b1;
        end else begin
          pos_c_d = pos_c_q - 1'b1;
        end
      end else begin
        if (pos_c_q == LAST_COL) begin
          pos_c_d = '0;
          pos_r_d = pos_r_q + 1'b1;
        end else begin
          pos_c_d = pos_c_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      wr_q   <= '0;
    end else begin
      busy_q <= busy_d;
      wr_q   <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_r_q <= pos_r_d;
    pos_c_q <= pos_c_d;
    if (start_i) begin
      desc_q <= desc_i;
    end
  end

  assign wr_o   = wr_q;
  assign idle_o = ~busy_q & ~wr_q.we;

endmodule

@@ rtl/terminal_text_screen_engine.sv @@
// Terminal text screen engine top level: command decode FSM, cursor state,
// screen and alternate glyph RAMs, cell walker. Depends on tts_pkg,
// tts_ram and tts_walker.
// Each command passes EXEC, then WALK for a walk or READ for read, then DONE,
// where the result is loaded; a walk steps over a range of cells (whole
// screen: ROWS*COLUMNS cells, 1920 by default). Throughput: one transaction
// at a time, tready returns in the cycle after the result is loaded, bounded by the
// one cell per cycle read/write port of the RAMs. After reset a clearing pass
// writes blank to ROWS*128 addresses (3072 by default) with tready low.
module terminal_text_screen_engine import tts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[4:0], char_code[12:5], target_col[20:13], target_row[28:21],
  // repeat_count[36:29], region_top[44:37], region_bottom[52:45], inverse_on[53]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cursor_col[6:0], cursor_row[11:7], cell_glyph[19:12]
  output logic [23:0] m_axis_tdata
);

  state_e state_q, state_d;

  logic [55:0]       cmd_q;
  logic [ADDR_W-1:0] clr_q;
  logic [COL_W-1:0]  cc_q, cc_d, sc_q, sc_d;
  logic [ROW_W-1:0]  cr_q, cr_d, sr_q, sr_d, top_q, top_d, bot_q, bot_d;
  logic              inv_q, inv_d;
  logic [7:0]        glyph_q;
  logic              m_valid_q;
  logic [19:0]       m_data_q;

  logic [4:0] f_req;
  logic [7:0] f_ch, f_tc, f_tr, f_n, f_top, f_bot;
  logic       f_inv;

  logic              walk_go, put_we, do_read, load_out;
  walk_t             desc;
  logic [ADDR_W-1:0] rd_addr, wk_raddr, ram_raddr;
  wr_t               wk_wr;
  logic              wk_idle;
  logic [7:0]        glyph, scr_rdata, alt_rdata, wk_data;
  logic [7:0]        nn, tmp_bot;
  logic [5:0]        span;
  logic [8:0]        ech_end;
  logic [COL_W-1:0]  clamp_c;
  logic [ROW_W-1:0]  clamp_r;

  logic              scr_we, alt_we;
  logic [ADDR_W-1:0] scr_waddr, alt_waddr;
  logic [7:0]        scr_wdata, alt_wdata;

  assign f_req = cmd_q[4:0];
  assign f_ch  = cmd_q[12:5];
  assign f_tc  = cmd_q[20:13];
  assign f_tr  = cmd_q[28:21];
  assign f_n   = cmd_q[36:29];
  assign f_top = cmd_q[44:37];
  assign f_bot = cmd_q[52:45];
  assign f_inv = cmd_q[53];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign load_out      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_EXEC;
      ST_EXEC: begin
        if (walk_go)      state_d = ST_WALK;
        else if (do_read) state_d = ST_READ;
        else              state_d = ST_DONE;
      end
      ST_WALK:  if (wk_idle) state_d = ST_DONE;
      ST_READ:  state_d = ST_DONE;
      ST_DONE:  if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // glyph for put
  always_comb begin
    if (inv_q) begin
      glyph = f_ch[6] ? {3'b000, f_ch[4:0]} : {2'b00, f_ch[5:0]};
    end else begin
      glyph = {1'b1, f_ch[6:0]};
    end
  end

  assign clamp_c = (f_tc > 8'(LAST_COL)) ? LAST_COL : f_tc[COL_W-1:0];
  assign clamp_r = (f_tr > 8'(LAST_ROW)) ? LAST_ROW : f_tr[ROW_W-1:0];

  // command decode
  always_comb begin
    cc_d    = cc_q;
    cr_d    = cr_q;
    sc_d    = sc_q;
    sr_d    = sr_q;
    top_d   = top_q;
    bot_d   = bot_q;
    inv_d   = inv_q;
    walk_go = 1'b0;
    put_we  = 1'b0;
    do_read = 1'b0;
    rd_addr = {clamp_r, clamp_c};
    tmp_bot = '0;
    span    = 6'(bot_q) - 6'(cr_q) + 6'd1;
    nn      = (f_n == 8'd0) ? 8'd1 : f_n;
    ech_end = '0;

    desc            = '0;
    desc.r0         = cr_q;
    desc.r1         = cr_q;
    desc.c0         = cc_q;
    desc.c1         = LAST_COL;
    desc.hi         = 8'hFF;
    desc.fill_blank = 1'b1;

    if (state_q == ST_EXEC) begin
      case (f_req)
        REQ_PUT, REQ_LF: begin
          if (f_req == REQ_PUT) begin
            put_we = 1'b1;
            cc_d   = cc_q + 1'b1;
          end
          if (f_req == REQ_LF || cc_q == LAST_COL) begin
            if (f_req == REQ_PUT) cc_d = '0;
            if (cr_q == bot_q) begin
              walk_go         = 1'b1;
              desc.r0         = top_q;
              desc.c0         = '0;
              desc.r1         = bot_q;
              desc.on_row     = 1'b1;
              desc.delta      = 10'sd1;
              desc.hi         = 8'(bot_q);
              desc.fill_blank = 1'b0;
            end else if (cr_q != LAST_ROW) begin
              cr_d = cr_q + 1'b1;
            end
          end
        end
        REQ_GOTO: begin
          cc_d = clamp_c;
          cr_d = clamp_r;
        end
        REQ_CR: cc_d = '0;
        REQ_RI: begin
          if (cr_q == top_q) begin
            walk_go         = 1'b1;
            desc.down       = 1'b1;
            desc.r0         = bot_q;
            desc.c0         = LAST_COL;
            desc.r1         = top_q;
            desc.c1         = '0;
            desc.on_row     = 1'b1;
            desc.delta      = -10'sd1;
            desc.lo         = 8'(top_q);
            desc.fill_blank = 1'b0;
          end else if (cr_q != '0) begin
            cr_d = cr_q - 1'b1;
          end
        end
        REQ_BS: if (cc_q != '0) cc_d = cc_q - 1'b1;
        REQ_REGION: begin
          tmp_bot = (f_bot > 8'(LAST_ROW)) ? 8'(LAST_ROW) : f_bot;
          if (f_top >= tmp_bot) begin
            top_d = '0;
            bot_d = LAST_ROW;
          end else begin
            top_d = f_top[ROW_W-1:0];
            bot_d = tmp_bot[ROW_W-1:0];
          end
          cc_d = '0;
          cr_d = '0;
        end
        REQ_IL, REQ_DL: begin
          nn = (f_n > 8'(span)) ? 8'(span) : f_n;
          if (f_n != 8'd0 && cr_q >= top_q && cr_q <= bot_q) begin
            walk_go         = 1'b1;
            desc.on_row     = 1'b1;
            desc.fill_blank = 1'b0;
            if (f_req == REQ_IL) begin
              desc.down  = 1'b1;
              desc.r0    = bot_q;
              desc.c0    = LAST_COL;
              desc.r1    = cr_q;
              desc.c1    = '0;
              desc.delta = ~{2'b00, nn} + 10'd1;
              desc.lo    = 8'(cr_q);
            end else begin
              desc.r0    = cr_q;
              desc.c0    = '0;
              desc.r1    = bot_q;
              desc.delta = {2'b00, nn};
              desc.hi    = 8'(bot_q);
            end
          end
        end
        REQ_ICH: begin
          if (nn > 8'(LAST_COL - cc_q) + 8'd1) nn = 8'(LAST_COL - cc_q) + 8'd1;
          walk_go         = 1'b1;
          desc.down       = 1'b1;
          desc.c0         = LAST_COL;
          desc.c1         = cc_q;
          desc.delta      = ~{2'b00, nn} + 10'd1;
          desc.lo         = 8'(cc_q);
          desc.fill_blank = 1'b0;
        end
        REQ_DCH: begin
          walk_go         = 1'b1;
          desc.delta      = {2'b00, nn};
          desc.hi         = 8'(LAST_COL);
          desc.fill_blank = 1'b0;
        end
        REQ_ECH: begin
          walk_go = 1'b1;
          ech_end = 9'(cc_q) + 9'(nn) - 9'd1;
          desc.c1 = (ech_end > 9'(LAST_COL)) ? LAST_COL : ech_end[COL_W-1:0];
        end
        REQ_EL_END: walk_go = 1'b1;
        REQ_EL_START: begin
          walk_go = 1'b1;
          desc.c0 = '0;
          desc.c1 = cc_q;
        end
        REQ_EL_ALL: begin
          walk_go = 1'b1;
          desc.c0 = '0;
        end
        REQ_ED_START: begin
          walk_go = 1'b1;
          desc.r0 = '0;
          desc.c0 = '0;
          desc.c1 = cc_q;
        end
        REQ_ED_END: begin
          walk_go = 1'b1;
          desc.r1 = LAST_ROW;
        end
        REQ_ED_ALL, REQ_SAVE, REQ_RESTORE: begin
          walk_go = 1'b1;
          desc.r0 = '0;
          desc.c0 = '0;
          desc.r1 = LAST_ROW;
          if (f_req == REQ_ED_ALL) begin
            cc_d = '0;
            cr_d = '0;
          end else if (f_req == REQ_SAVE) begin
            desc.fill_blank = 1'b0;
            desc.dst_alt    = 1'b1;
            sc_d            = cc_q;
            sr_d            = cr_q;
          end else begin
            desc.fill_blank = 1'b0;
            desc.src_alt    = 1'b1;
            cc_d            = sc_q;
            cr_d            = sr_q;
          end
        end
        REQ_ATTR: inv_d = f_inv;
        REQ_READ: do_read = 1'b1;
        default: ;
      endcase
    end
  end

  tts_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_go),
    .desc_i  (desc),
    .raddr_o (wk_raddr),
    .wr_o    (wk_wr),
    .idle_o  (wk_idle)
  );

  assign wk_data   = wk_wr.blank ? BLANK : (wk_wr.src_alt ? alt_rdata : scr_rdata);
  assign ram_raddr = (state_q == ST_EXEC) ? rd_addr : wk_raddr;

  always_comb begin
    scr_we    = 1'b0;
    scr_waddr = wk_wr.addr;
    scr_wdata = wk_data;
    alt_we    = 1'b0;
    alt_waddr = wk_wr.addr;
    alt_wdata = wk_data;
    if (state_q == ST_CLEAR) begin
      scr_we    = 1'b1;
      scr_waddr = clr_q;
      scr_wdata = BLANK;
      alt_we    = 1'b1;
      alt_waddr = clr_q;
      alt_wdata = BLANK;
    end else if (put_we) begin
      scr_we    = 1'b1;
      scr_waddr = {cr_q, cc_q};
      scr_wdata = glyph;
    end else if (wk_wr.we) begin
      scr_we = ~wk_wr.dst_alt;
      alt_we = wk_wr.dst_alt;
    end
  end

  tts_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (scr_rdata)
  );

  tts_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_alt_ram (
    .clk_i   (clk_i),
    .we_i    (alt_we),
    .waddr_i (alt_waddr),
    .wdata_i (alt_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (alt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      cc_q      <= '0;
      cr_q      <= '0;
      sc_q      <= '0;
      sr_q      <= '0;
      top_q     <= '0;
      bot_q     <= LAST_ROW;
      inv_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      cc_q  <= cc_d;
      cr_q  <= cr_d;
      sc_q  <= sc_d;
      sr_q  <= sr_d;
      top_q <= top_d;
      bot_q <= bot_d;
      inv_q <= inv_d;
      if (load_out)           m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) cmd_q <= s_axis_tdata;
    if (state_q == ST_EXEC)      glyph_q <= '0;
    else if (state_q == ST_READ) glyph_q <= scr_rdata;
    if (load_out) m_data_q <= {glyph_q, cr_q, cc_q};
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_data_q};

endmodule
